@@ rtl/b58_pkg.sv @@
// b58_pkg: shared types and constants for the base-58 encoder
// no dependencies; imported by b58_cell, base58_encoder and b58_checker

package b58_pkg;

   localparam int DigitWidth = 6;
   localparam int ByteWidth  = 8;
   localparam int CountWidth = 6;
   localparam int CharWidth  = 7;

   // one digit times 256 plus a carry fits in 14 bits
   localparam int ValueWidth = DigitWidth + ByteWidth;
   localparam logic [ValueWidth-1:0] Radix = ValueWidth'(58);

   // divide by 58 as a multiply by a scaled reciprocal
   localparam int DivShift  = 20;
   localparam int DivWidth  = 15;
   localparam logic [DivWidth-1:0] DivMul = DivWidth'(18079);
   localparam int ProdWidth = ValueWidth + DivWidth;

   // digits per byte, log(256)/log(58), in 24-bit fixed point
   localparam int RatioShift = 24;
   localparam int RatioWidth = 25;
   localparam longint RatioFull = (64'd16777216 * 64'd1000000000) / 64'd732247624;
   localparam logic [RatioWidth-1:0] DigitRatio = RatioWidth'(RatioFull);
   localparam int SizeWidth = 8;

   localparam logic [CharWidth-1:0] CharOne   = CharWidth'(49);
   localparam logic [CharWidth-1:0] CharUpA   = CharWidth'(65);
   localparam logic [CharWidth-1:0] CharUpJ   = CharWidth'(74);
   localparam logic [CharWidth-1:0] CharUpP   = CharWidth'(80);
   localparam logic [CharWidth-1:0] CharLowA  = CharWidth'(97);
   localparam logic [CharWidth-1:0] CharLowM  = CharWidth'(109);
   localparam logic [CharWidth-1:0] CharLowZ  = CharWidth'(122);

   typedef struct packed {
      logic                 go;
      logic [ByteWidth-1:0] carry;
   } b58_link_type;

   // alphabet without 0, O, I and l
   function automatic logic [CharWidth-1:0] b58_char(input logic [DigitWidth-1:0] digit);
      logic [CharWidth-1:0] d;
      logic [CharWidth-1:0] c;
      d = CharWidth'(digit);
      if (digit < DigitWidth'(9)) begin
         c = CharOne + d;
      end else if (digit < DigitWidth'(17)) begin
         c = CharUpA + d - CharWidth'(9);
      end else if (digit < DigitWidth'(22)) begin
         c = CharUpJ + d - CharWidth'(17);
      end else if (digit < DigitWidth'(33)) begin
         c = CharUpP + d - CharWidth'(22);
      end else if (digit < DigitWidth'(44)) begin
         c = CharLowA + d - CharWidth'(33);
      end else if (digit < DigitWidth'(58)) begin
         c = CharLowM + d - CharWidth'(44);
      end else begin
         c = CharLowZ;
      end
      return c;
   endfunction

endpackage

@@ rtl/b58_cell.sv @@
// b58_cell: one base-58 digit of the store, multiply-by-256 carry step
// depends on b58_pkg; instantiated in a row by base58_encoder

module b58_cell import b58_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  b58_link_type          link_in,
   output b58_link_type          link_out,
   input  logic [DigitWidth-1:0] shift_digit,
   output logic [DigitWidth-1:0] digit_out
);

   logic [DigitWidth-1:0] digit_ff, digit_in;
   logic                  go_ff, go_in;
   logic [ByteWidth-1:0]  carry_ff, carry_in;

   logic [ValueWidth-1:0] value;
   logic [ProdWidth-1:0]  prod;
   logic [ByteWidth-1:0]  quot;
   logic [ValueWidth-1:0] rem_full;

   always_comb begin
      value    = {digit_ff, ByteWidth'(0)} + ValueWidth'(link_in.carry);
      prod     = ProdWidth'(value) * ProdWidth'(DivMul);
      quot     = prod[DivShift +: ByteWidth];
      rem_full = value - ValueWidth'(quot) * Radix;
      go_in    = link_in.go && !shift;
      carry_in = quot;
      if (shift) begin
         digit_in = shift_digit;
      end else if (link_in.go) begin
         digit_in = rem_full[DigitWidth-1:0];
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         go_ff    <= 1'b0;
      end else begin
         digit_ff <= digit_in;
         go_ff    <= go_in;
      end
      carry_ff <= carry_in;
   end

   assign link_out  = '{go: go_ff, carry: carry_ff};
   assign digit_out = digit_ff;

endmodule

@@ rtl/base58_encoder.sv @@
// base58_encoder: top level, row of digit cells plus message control
// depends on b58_pkg and b58_cell
//
// Encodes a byte message, most significant byte first, into base-58 characters of the
// Bitcoin alphabet, leading zero digits included, most significant digit first. Each
// accepted byte must be absorbed before the next can be taken: its carry walks the row
// of MAX_DIGITS cells from the least significant digit up, one cell a cycle, then the
// SIZE state sizes the result; a dropped byte past MAX_BYTES goes through SIZE only.
// After the last byte the row shifts out MAX_DIGITS digits, one per cycle when the
// output is not stalled, the leading ones beyond the digit count being discarded;
// the shift also clears the store for the next message. Input stall is high for all
// of that work.

module base58_encoder import b58_pkg::*; #(
   parameter int MAX_BYTES  = 32,
   parameter int MAX_DIGITS = 44
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_data_byte,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CharWidth-1:0] rsp_digit_char,
   output logic                 rsp_last_digit,
   output logic                 rsp_overflow
);

   localparam int KWidth = $clog2(MAX_DIGITS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ABSORB = 2'd1;
   localparam logic [1:0] ST_SIZE   = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;
   logic [KWidth-1:0]     k_ff, k_in;
   logic [KWidth-1:0]     start_ff, start_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  lastd_ff, lastd_in;
   logic                  rovf_ff, rovf_in;

   logic                  accept, inject, out_free, step, load, k_end;
   logic [31:0]           size_prod;
   logic [SizeWidth-1:0]  size_raw, size_cnt, start_wide;

   b58_link_type          lnk [MAX_DIGITS+1];
   logic [DigitWidth-1:0] dig [MAX_DIGITS+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign inject    = accept && (count_ff < CountWidth'(MAX_BYTES));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = (state_ff == ST_EMIT) && out_free;
   assign load      = step && (k_ff >= start_ff);
   assign k_end     = (k_ff == KWidth'(MAX_DIGITS - 1));

   assign lnk[MAX_DIGITS] = '{go: inject, carry: req_data_byte};
   assign dig[MAX_DIGITS] = '0;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      b58_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (step),
         .link_in     (lnk[i+1]),
         .link_out    (lnk[i]),
         .shift_digit (dig[i+1]),
         .digit_out   (dig[i])
      );
   end

   always_comb begin
      size_prod  = 32'(count_ff) * 32'(DigitRatio);
      size_raw   = SizeWidth'(size_prod >> RatioShift) + SizeWidth'(1);
      size_cnt   = (size_raw > SizeWidth'(MAX_DIGITS)) ? SizeWidth'(MAX_DIGITS) : size_raw;
      start_wide = SizeWidth'(MAX_DIGITS) - size_cnt;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      k_in     = k_ff;
      start_in = start_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last;
               if (inject) begin
                  count_in = count_ff + CountWidth'(1);
                  state_in = ST_ABSORB;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = ST_SIZE;
               end
            end
         end
         ST_ABSORB: begin
            if (lnk[0].go) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            start_in = start_wide[KWidth-1:0];
            k_in     = '0;
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (step) begin
               k_in = k_ff + KWidth'(1);
               if (k_end) begin
                  k_in     = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      char_in      = load ? b58_char(dig[0]) : char_ff;
      lastd_in     = load ? k_end : lastd_ff;
      rovf_in      = load ? ovf_ff : rovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         k_ff         <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         k_ff         <= k_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff  <= char_in;
      lastd_ff <= lastd_in;
      rovf_ff  <= rovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = lastd_ff;
   assign rsp_overflow   = rovf_ff;

endmodule

@@ rtl/b58_checker.sv @@
// b58_checker: port-level assertions for base58_encoder
// depends on b58_pkg; bound to base58_encoder below

module b58_checker import b58_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [ByteWidth-1:0] req_data_byte,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CharWidth-1:0] rsp_digit_char,
   input logic                 rsp_last_digit,
   input logic                 rsp_overflow
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
         && $stable(rsp_last_digit) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // stalled input transfer holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte) && $stable(req_last))
      else $error("stalled input changed");

   // every input transfer is followed by input stall going high
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on back-to-back cycles");

   // a message is still being emitted until its final digit
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |-> req_stall)
      else $error("input open before final digit");

   // overflow flag constant across one message
   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_digit
         |=> !rsp_valid || (rsp_overflow == $past(rsp_overflow)))
      else $error("overflow flag changed within a message");

endmodule

bind base58_encoder b58_checker u_b58_checker (.*);
